// ===== design/lltb_pkg.sv =====
// Package for the loudness to LED brightness block.
// Holds the configuration and queue word types, register codes and fixed constants.
// No dependencies; every other file of the block except lltb_div.sv imports it.
package lltb_pkg;

   // Register indexes on the configuration port, one 32-bit register per word address.
   localparam logic [1:0] REG_BASE_RED   = 2'd0;
   localparam logic [1:0] REG_BASE_GREEN = 2'd1;
   localparam logic [1:0] REG_BASE_BLUE  = 2'd2;
   localparam logic [1:0] REG_PEAK_FLOOR = 2'd3;

   // Word kinds carried on req_tuser.
   localparam logic SAMPLE_WORD = 1'b0;
   localparam logic CLEAR_WORD  = 1'b1;

   localparam logic [7:0]  BASE_RED_RESET   = 8'd64;
   localparam logic [7:0]  BASE_GREEN_RESET = 8'd128;
   localparam logic [7:0]  BASE_BLUE_RESET  = 8'd255;
   localparam logic [15:0] PEAK_FLOOR_RESET = 16'd2000;

   // Colour scale is Q8.8: 220 / max component, capped at 2.5.
   localparam logic [15:0] SCALE_NUM = 16'd56320;
   localparam logic [9:0]  SCALE_CAP = 10'd640;

   // Queue between front and back; the depth must be a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0]  base_red;
      logic [7:0]  base_green;
      logic [7:0]  base_blue;
      logic [15:0] peak_floor;
   } lltb_cfg_type;

   // One classified word: either a reset of the smoothing state or a sample
   // together with the normalizing divisor the front worked out for it.
   typedef struct packed {
      logic        is_reset;
      logic [15:0] loudness;
      logic [15:0] divisor;
   } lltb_item_type;

endpackage

// ===== design/lltb_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Divides a W-bit dividend by a 16-bit nonzero divisor; uses no package items.
module lltb_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [15:0]  divisor,
   output logic         busy,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quot_ff;
   logic [15:0]   rem_ff;
   logic [15:0]   div_ff;
   logic [CW-1:0] count_ff;
   logic          busy_ff;
   logic [16:0]   trial_in;
   logic          fits_in;

   assign trial_in = {rem_ff, quot_ff[W-1]};
   assign fits_in  = trial_in >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CW'(W);
      end else if (busy_ff) begin
         count_ff <= count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         if (fits_in) begin
            rem_ff <= 16'(trial_in - {1'b0, div_ff});
         end else begin
            rem_ff <= trial_in[15:0];
         end
         quot_ff <= {quot_ff[W-2:0], fits_in};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== design/lltb_front.sv =====
// Front end: accepts input words, tracks the decaying peak and works out the divisor.
// Depends on lltb_pkg for the configuration and queue word types.
module lltb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_type,
   input  logic [15:0]            in_loudness,
   output logic                   in_ready,
   input  lltb_pkg::lltb_cfg_type cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output lltb_pkg::lltb_item_type q_item
);
   import lltb_pkg::*;

   logic [15:0] peak_ff;
   logic [15:0] peak_in;
   logic [23:0] peak_dec;
   logic [15:0] floor_v;

   // peak * 255 / 256, truncated.
   assign peak_dec = {peak_ff, 8'd0} - {8'd0, peak_ff};
   assign peak_in  = (in_loudness > peak_ff) ? in_loudness : peak_dec[23:8];
   assign floor_v  = (cfg.peak_floor == 16'd0) ? 16'd1 : cfg.peak_floor;

   assign in_ready = !q_full;
   assign q_push   = in_valid && in_ready;

   always_comb begin
      q_item.is_reset = in_type;
      q_item.loudness = in_loudness;
      q_item.divisor  = (peak_in > floor_v) ? peak_in : floor_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (q_push) begin
         peak_ff <= in_type ? 16'd0 : peak_in;
      end
   end

endmodule

// ===== design/lltb_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on lltb_pkg for the queue word type and depth.
module lltb_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lltb_pkg::lltb_item_type push_item,
   input  logic                    pop,
   output lltb_pkg::lltb_item_type head_item,
   output logic                    full,
   output logic                    empty
);
   import lltb_pkg::*;

   lltb_item_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign full      = count_ff == QCNT_W'(QDEPTH);
   assign empty     = count_ff == '0;
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QPTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue read while empty");
`endif

endmodule

// ===== design/lltb_back.sv =====
// Back end: normalizes, squares and smooths the level, scales the colours and clears the level on a reset word.
// Depends on lltb_pkg and instantiates two lltb_div units.
module lltb_back #(
   parameter int F = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lltb_pkg::lltb_cfg_type  cfg,
   input  logic                    q_empty,
   input  lltb_pkg::lltb_item_type q_item,
   output logic                    q_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [39:0]             out_data
);
   import lltb_pkg::*;

   localparam int NW = 16 + F;
   localparam logic [F-1:0] ATTACK_Q = F'((64'd7 << F) / 10);
   localparam logic [F-1:0] DECAY_Q  = F'((64'd6 << F) / 10);
   localparam int SH_R = (F >= 16) ? F - 16 : 0;
   localparam int SH_L = (F >= 16) ? 0 : 16 - F;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_SQ     = 3'd2;
   localparam logic [2:0] ST_SMOOTH = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;
   localparam logic [2:0] ST_BASE   = 3'd5;
   localparam logic [2:0] ST_COLOR  = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]      state_ff;
   logic [F-1:0]    smoothed_ff;
   logic [F-1:0]    norm_ff;
   logic [F-1:0]    target_ff;
   logic [F-1:0]    step_ff;
   logic            rise_ff;
   logic [9:0]      scale_ff;
   logic [17:0]     bs_ff;
   logic [1:0]      idx_ff;
   logic [7:0]      col_ff [3];
   logic            out_valid_ff;
   logic [39:0]     out_data_ff;

   logic            div_start;
   logic            norm_busy;
   logic            scale_busy;
   logic [NW-1:0]   norm_q;
   logic [15:0]     scale_q;
   logic [7:0]      maxc;
   logic [7:0]      base_sel;
   logic [2*F-1:0]  sq_prod;
   logic            rise_in;
   logic [F-1:0]    diff_in;
   logic [2*F-1:0]  step_prod;
   logic [17+F:0]   col_prod;
   logic [9:0]      col_val;
   logic [7:0]      col_sat;
   logic [31:0]     q16_wide;
   logic            out_free;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign div_start = q_pop && !q_item.is_reset;

   always_comb begin
      maxc = cfg.base_red;
      if (cfg.base_green > maxc) begin
         maxc = cfg.base_green;
      end
      if (cfg.base_blue > maxc) begin
         maxc = cfg.base_blue;
      end
      if (maxc == 8'd0) begin
         maxc = 8'd1;
      end
   end

   lltb_div #(.W(NW)) u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({q_item.loudness, F'(0)}),
      .divisor  (q_item.divisor),
      .busy     (norm_busy),
      .quotient (norm_q)
   );

   lltb_div #(.W(16)) u_scale_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SCALE_NUM),
      .divisor  ({8'd0, maxc}),
      .busy     (scale_busy),
      .quotient (scale_q)
   );

   always_comb begin
      case (idx_ff)
         2'd0:    base_sel = cfg.base_red;
         2'd1:    base_sel = cfg.base_green;
         2'd2:    base_sel = cfg.base_blue;
         default: base_sel = 8'd0;
      endcase
   end

   assign sq_prod   = (2*F)'(norm_ff) * (2*F)'(norm_ff);
   assign rise_in   = target_ff > smoothed_ff;
   assign diff_in   = rise_in ? (target_ff - smoothed_ff) : (smoothed_ff - target_ff);
   assign step_prod = (2*F)'(diff_in) * (2*F)'(rise_in ? ATTACK_Q : DECAY_Q);
   assign col_prod  = (18+F)'(bs_ff) * (18+F)'(smoothed_ff);
   assign col_val   = col_prod[17+F:8+F];
   assign col_sat   = (col_val > 10'd255) ? 8'd255 : col_val[7:0];
   assign q16_wide  = (32'(smoothed_ff) << SH_L) >> SH_R;
   assign out_free  = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         smoothed_ff  <= '0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // In the output state the valid flag is handled below, where a new word
         // may replace the one that leaves in the same cycle.
         if (out_valid_ff && out_ready && (state_ff != ST_OUT)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (q_item.is_reset) begin
                     smoothed_ff <= '0;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (!norm_busy && !scale_busy) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ:     state_ff <= ST_SMOOTH;
            ST_SMOOTH: state_ff <= ST_STEP;
            ST_STEP: begin
               smoothed_ff <= rise_ff ? (smoothed_ff + step_ff) : (smoothed_ff - step_ff);
               idx_ff      <= 2'd0;
               state_ff    <= ST_BASE;
            end
            ST_BASE:   state_ff <= ST_COLOR;
            ST_COLOR: begin
               if (idx_ff == 2'd2) begin
                  state_ff <= ST_OUT;
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= ST_BASE;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         norm_ff  <= (|norm_q[NW-1:F]) ? '1 : norm_q[F-1:0];
         scale_ff <= (scale_q > 16'(SCALE_CAP)) ? SCALE_CAP : scale_q[9:0];
      end
      if (state_ff == ST_SQ) begin
         target_ff <= sq_prod[2*F-1:F];
      end
      if (state_ff == ST_SMOOTH) begin
         rise_ff <= rise_in;
         step_ff <= step_prod[2*F-1:F];
      end
      if (state_ff == ST_BASE) begin
         bs_ff <= 18'(base_sel) * 18'(scale_ff);
      end
      if (state_ff == ST_COLOR) begin
         col_ff[idx_ff] <= col_sat;
      end
      if (state_ff == ST_OUT && out_free) begin
         out_data_ff <= {q16_wide[15:0], col_ff[2], col_ff[1], col_ff[0]};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.is_reset) |=> (smoothed_ff == '0))
      else $error("reset word did not clear the smoothed level");
   a_no_overshoot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |=>
         (rise_ff ? (smoothed_ff <= target_ff) : (smoothed_ff >= target_ff)))
      else $error("smoothed level stepped past its target");
`endif

endmodule

// ===== design/loudness_to_led_brightness.sv =====
// Top level of the loudness to LED brightness block.
// Holds the configuration registers and connects lltb_front, lltb_fifo and lltb_back.
// Depends on lltb_pkg.

// Each loudness sample word on the req_ stream produces one rsp_ word with red,
// green and blue LED brightness bytes and the smoothed level in Q0.16; a word with
// req_tuser high clears the peak and smoothed level and produces no rsp_ word. The
// front end takes a word whenever its two-entry queue has room, even while a
// finished result waits in the output register. The back end works on one
// sample at a time; the restoring divider produces the normalized level one
// quotient bit per cycle over 16 + LEVEL_FRAC_BITS bits. The back end handles
// a reset word in its idle state. The colour registers and the peak floor sit
// on an APB-style port at byte addresses 0, 4, 8 and 12 and should be written
// only while no sample is in flight.
module loudness_to_led_brightness #(
   parameter int LEVEL_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream. tdata: loudness [15:0]. tuser: req_type [0] (1 = reset word).
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   // Result stream. tdata: red_level [7:0], green_level [15:8], blue_level [23:16],
   // smoothed_out [39:24].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lltb_pkg::*;

   lltb_cfg_type  cfg_ff;
   lltb_item_type push_item;
   lltb_item_type head_item;
   logic          cfg_write;
   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;

   // The port never waits, so a write lands on its access cycle.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_red   <= BASE_RED_RESET;
         cfg_ff.base_green <= BASE_GREEN_RESET;
         cfg_ff.base_blue  <= BASE_BLUE_RESET;
         cfg_ff.peak_floor <= PEAK_FLOOR_RESET;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_BASE_RED:   cfg_ff.base_red   <= csr_pwdata[7:0];
            REG_BASE_GREEN: cfg_ff.base_green <= csr_pwdata[7:0];
            REG_BASE_BLUE:  cfg_ff.base_blue  <= csr_pwdata[7:0];
            REG_PEAK_FLOOR: cfg_ff.peak_floor <= csr_pwdata[15:0];
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BASE_RED:   csr_prdata = {24'd0, cfg_ff.base_red};
         REG_BASE_GREEN: csr_prdata = {24'd0, cfg_ff.base_green};
         REG_BASE_BLUE:  csr_prdata = {24'd0, cfg_ff.base_blue};
         REG_PEAK_FLOOR: csr_prdata = {16'd0, cfg_ff.peak_floor};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // The front end owns the peak, since it depends only on the order of samples.
   lltb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_type     (req_tuser),
      .in_loudness (req_tdata),
      .in_ready    (req_tready),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   lltb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   lltb_back #(.F(LEVEL_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// ===== test/lltb_brightness_checker.sv =====
// Checker for the loudness to LED brightness block: follows the register port, predicts
// every result word from the accepted input words and compares them in order.
// Depends on lltb_pkg for the register codes, reset values, scale constants and types.
module lltb_brightness_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          words_due
);
   import lltb_pkg::*;

   localparam int   PRINT_LIMIT = 40;

   // Smoothing gains in Q0.16, truncated.
   localparam logic [31:0] ATTACK_GAIN = 32'd45875;
   localparam logic [31:0] DECAY_GAIN  = 32'd39321;

   typedef struct packed {
      logic [15:0] level;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } led_word_type;

   lltb_cfg_type settings;
   logic [15:0]  peak_now;
   logic [15:0]  smooth_now;
   led_word_type brightness_due[$];

   initial fail_count = 0;
   initial words_due = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic logic [31:0] register_value(input logic [1:0] index);
      case (index)
         REG_BASE_RED:   return 32'(settings.base_red);
         REG_BASE_GREEN: return 32'(settings.base_green);
         REG_BASE_BLUE:  return 32'(settings.base_blue);
         default:        return 32'(settings.peak_floor);
      endcase
   endfunction

   function automatic logic [7:0] scaled_colour(input logic [7:0] base, input logic [31:0] scale,
                                                input logic [15:0] level);
      logic [63:0] product;
      product = (64'(base) * 64'(scale) * 64'(level)) >> 24;
      return (product > 64'd255) ? 8'd255 : product[7:0];
   endfunction

   // Moves the peak and the smoothed level on by one sample and gives the LED word.
   function automatic void advance_brightness(input logic [15:0] loud,
                                              output led_word_type word);
      logic [31:0] divisor;
      logic [31:0] norm;
      logic [31:0] target;
      logic [31:0] step;
      logic [31:0] scale;
      logic [7:0]  top_colour;
      if (loud > peak_now)
         peak_now = loud;
      else
         peak_now = 16'((32'(peak_now) * 32'd255) >> 8);

      // A zero floor counts as one so the divisor never vanishes.
      divisor = (settings.peak_floor == 16'd0) ? 32'd1 : 32'(settings.peak_floor);
      if (32'(peak_now) > divisor)
         divisor = 32'(peak_now);
      norm = {loud, 16'h0000} / divisor;
      if (norm > 32'h0000_FFFF)
         norm = 32'h0000_FFFF;
      target = (norm * norm) >> 16;

      if (target > 32'(smooth_now)) begin
         step = ((target - 32'(smooth_now)) * ATTACK_GAIN) >> 16;
         smooth_now = smooth_now + step[15:0];
      end else begin
         step = ((32'(smooth_now) - target) * DECAY_GAIN) >> 16;
         smooth_now = smooth_now - step[15:0];
      end

      top_colour = settings.base_red;
      if (settings.base_green > top_colour) top_colour = settings.base_green;
      if (settings.base_blue > top_colour) top_colour = settings.base_blue;
      if (top_colour == 8'd0) top_colour = 8'd1;
      scale = 32'(SCALE_NUM) / 32'(top_colour);
      if (scale > 32'(SCALE_CAP))
         scale = 32'(SCALE_CAP);

      word.red   = scaled_colour(settings.base_red, scale, smooth_now);
      word.green = scaled_colour(settings.base_green, scale, smooth_now);
      word.blue  = scaled_colour(settings.base_blue, scale, smooth_now);
      word.level = smooth_now;
   endfunction

   always @(posedge clock) begin
      led_word_type want;
      led_word_type got;
      if (reset) begin
         settings.base_red   = BASE_RED_RESET;
         settings.base_green = BASE_GREEN_RESET;
         settings.base_blue  = BASE_BLUE_RESET;
         settings.peak_floor = PEAK_FLOOR_RESET;
         peak_now = 16'd0;
         smooth_now = 16'd0;
         brightness_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_BASE_RED:   settings.base_red = csr_pwdata[7:0];
                  REG_BASE_GREEN: settings.base_green = csr_pwdata[7:0];
                  REG_BASE_BLUE:  settings.base_blue = csr_pwdata[7:0];
                  default:        settings.peak_floor = csr_pwdata[15:0];
               endcase
            end else if (csr_prdata !== register_value(csr_paddr[3:2])) begin
               report_mismatch($sformatf("register read at %0d", csr_paddr), csr_prdata,
                               register_value(csr_paddr[3:2]));
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (brightness_due.size() == 0) begin
               report_mismatch("result word with none due, smoothed level",
                               32'(got.level), 32'd0);
            end else begin
               want = brightness_due.pop_front();
               if (got.red !== want.red)
                  report_mismatch("red level", 32'(got.red), 32'(want.red));
               if (got.green !== want.green)
                  report_mismatch("green level", 32'(got.green), 32'(want.green));
               if (got.blue !== want.blue)
                  report_mismatch("blue level", 32'(got.blue), 32'(want.blue));
               if (got.level !== want.level)
                  report_mismatch("smoothed level", 32'(got.level), 32'(want.level));
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == CLEAR_WORD) begin
               peak_now = 16'd0;
               smooth_now = 16'd0;
            end else begin
               advance_brightness(req_tdata, want);
               brightness_due.push_back(want);
            end
         end
      end
      words_due <= brightness_due.size();
   end

endmodule

// ===== test/tb.sv =====
// Top of the loudness to LED brightness testbench: clock, reset, stimulus and verdict.
// Depends on lltb_pkg, the block loudness_to_led_brightness and lltb_brightness_checker.
module tb;
   import lltb_pkg::*;

   // A clear word can still be working its way through the block after the last
   // result, so register writes wait this long.
   localparam int DRAIN_CYCLES    = 100;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT     = 3000;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 75;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_LONG_STALLS
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int words_due;

   // Sender burst bookkeeping: words left in the current burst, and whether the
   // current phase sends its bursts with no gaps between them.
   int burst_left = 0;
   bit steady = 1'b0;

   // Receiver pattern state.
   ready_mode_type ready_mode = READY_ALWAYS;
   int ready_span = 0;
   int stall_left = 0;

   int quiet_cycles = 0;

   always #5 clock = ~clock;

   loudness_to_led_brightness DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lltb_brightness_checker monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .words_due   (words_due)
   );

   // Sends one word. It is called at a falling edge and returns at the falling edge
   // after the word was taken, with tvalid still high so that a following word goes
   // out without a bubble. Anything that pauses the sender lowers tvalid first.
   task automatic send_word(input logic kind, input logic [15:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            // Junk on the data lines while idle must not matter.
            req_tvalid <= 1'b0;
            req_tdata <= 16'($urandom);
            req_tuser <= 1'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted result word has come back.
   // The loop always waits on the clock before it checks, so tvalid is never lowered and raised in one step.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
   endtask

   // One register transfer: a setup phase, then the access phase until pready, then
   // an idle phase with psel low so that back-to-back transfers never collide on psel.
   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Writes the colour and the floor once the block is idle, then reads them all back.
   // The unused upper bits of each write carry junk that the block must drop.
   task automatic apply_settings(input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue, input logic [15:0] floor_value);
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_access(1'b1, REG_BASE_RED, {24'($urandom), red});
      csr_access(1'b1, REG_BASE_GREEN, {24'($urandom), green});
      csr_access(1'b1, REG_BASE_BLUE, {24'($urandom), blue});
      csr_access(1'b1, REG_PEAK_FLOOR, {16'($urandom), floor_value});
      csr_access(1'b0, REG_BASE_RED, 32'd0);
      csr_access(1'b0, REG_BASE_GREEN, 32'd0);
      csr_access(1'b0, REG_BASE_BLUE, 32'd0);
      csr_access(1'b0, REG_PEAK_FLOOR, 32'd0);
   endtask

   // Loudness for a random sample. The mix leans on quiet passages and silence so the
   // peak decays and the smoothing falls, with loud hits and full scale in between,
   // and values near the last one to sit around the current peak.
   function automatic logic [15:0] pick_loudness(input logic [15:0] recent);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return 16'($urandom);
      else if (roll < 55)
         return 16'($urandom_range(0, 4000));
      else if (roll < 68)
         return 16'd0;
      else if (roll < 84)
         return recent + 16'($urandom_range(0, 64)) - 16'd32;
      else if (roll < 92)
         return 16'hFFFF;
      else
         return 16'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [15:0] recent;
      logic [15:0] loud;
      recent = 16'd0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset colour and floor: silence, full scale, a repeat
      // of the peak (which then decays), falling levels, a clear word in the middle
      // of activity, and samples just around the floor.
      send_word(SAMPLE_WORD, 16'd0);
      send_word(SAMPLE_WORD, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'd30000);
      send_word(SAMPLE_WORD, 16'd0);
      send_word(SAMPLE_WORD, 16'd0);
      send_word(SAMPLE_WORD, 16'd0);
      send_word(CLEAR_WORD, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'd1);
      send_word(SAMPLE_WORD, 16'd2000);
      send_word(SAMPLE_WORD, 16'd1999);
      send_word(SAMPLE_WORD, 16'd40000);
      send_word(CLEAR_WORD, 16'd0);

      // An all-black colour gives zero brightness everywhere, and a zero floor must
      // behave as a floor of one, so even a sample of one normalizes to full scale.
      apply_settings(8'd0, 8'd0, 8'd0, 16'd0);
      send_word(SAMPLE_WORD, 16'd1);
      send_word(SAMPLE_WORD, 16'd0);
      send_word(SAMPLE_WORD, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'd2);
      send_word(CLEAR_WORD, 16'h5A5A);
      send_word(SAMPLE_WORD, 16'd7);

      // The smallest colour hits the scale cap; the largest floor holds the divisor at full scale.
      apply_settings(8'd1, 8'd1, 8'd1, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'hFFFF);
      send_word(SAMPLE_WORD, 16'hFFFE);
      send_word(SAMPLE_WORD, 16'd1);

      // Random part: every phase changes the colour and the floor, the first four
      // to fixed values and the rest at random.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_settings(8'd255, 8'd255, 8'd255, 16'hFFFF);
            1: apply_settings(8'd255, 8'd0, 8'd0, 16'd1);
            2: apply_settings(8'd0, 8'd0, 8'd37, 16'd0);
            3: apply_settings(8'd1, 8'd2, 8'd3, 16'd2000);
            default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                    ($urandom_range(0, 1) == 0) ?
                                    16'($urandom_range(1, 3000)) : 16'($urandom));
         endcase
         steady = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // Now and then the sender holds off until the block has drained.
            if ($urandom_range(0, 39) == 0)
               wait_for_quiet();
            if ($urandom_range(0, 24) == 0) begin
               send_word(CLEAR_WORD, 16'($urandom));
            end else begin
               loud = pick_loudness(recent);
               recent = loud;
               send_word(SAMPLE_WORD, loud);
            end
         end
      end

      // Let every result come back, then give the block time to settle before
      // deciding; a hang here is caught by the watchdog.
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && words_due == 0) begin
         $display("loudness_to_led_brightness: match");
      end else begin
         $display("loudness_to_led_brightness: mismatch");
      end
      $finish;
   end

   // The receiver keeps its own pattern: it switches at random times between
   // always ready, a coin toss, rarely ready, and mostly ready with long stalls.
   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_span = $urandom_range(100, 400);
      end
      ready_span--;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(5, 30);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Watchdog: any accepted word on any port restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("loudness_to_led_brightness: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
